// ===== hdl/lzwcd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwcd_pkg
// Shared types and constants of the LZW code decoder.
// ----------------------------------------------------------------------------
package lzwcd_pkg;

   localparam int CODE_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int WIDTH_W = 5;
   localparam int LIMIT_W = 17;

   // widest code; sets dictionary depth and stack depth
   localparam int MAX_CODE_BITS = 16;

   localparam logic [CODE_W-1:0]  END_CODE          = 16'd256;
   localparam int                 FIRST_FREE        = 257;
   localparam logic [WIDTH_W-1:0] START_WIDTH       = 5'd9;
   localparam int                 START_WIDTH_LIMIT = 512;
   localparam logic [LIMIT_W-1:0] LIMIT_AT_RESET    = 17'h10000;

   localparam logic OP_CODE = 1'b0;
   localparam logic OP_CONT = 1'b1;

   // item passed from front to back
   typedef struct packed {
      logic              op;
      logic [CODE_W-1:0] code;
      logic              is_end;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_USE,
      ST_FIRST,
      ST_FIX,
      ST_DRAIN_START,
      ST_DRAIN_RD,
      ST_DRAIN_OUT,
      ST_EMPTY_OUT
   } state_type;

endpackage

// ===== hdl/lzwcd_front.sv =====
// ----------------------------------------------------------------------------
// lzwcd_front
// Accepts request items, tags end codes and queues them for the back end.
// ----------------------------------------------------------------------------
module lzwcd_front
   import lzwcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [CODE_W-1:0] req_code,
   output logic              item_valid,
   output item_type          item,
   input  logic              item_ready
);

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // classify and store on transfer
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff].op     <= req_op;
         queue_ff[wr_ptr_ff].code   <= req_code;
         queue_ff[wr_ptr_ff].is_end <= (req_code == END_CODE);
      end
   end

endmodule

// ===== hdl/lzwcd_back.sv =====
// ----------------------------------------------------------------------------
// lzwcd_back
// Dictionary walk, string stack and result output of the LZW decoder.
// ----------------------------------------------------------------------------
module lzwcd_back
   import lzwcd_pkg::*;
#(
   parameter int BYTES_PER_ITEM = 64
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  item_type           item,
   output logic               item_ready,
   input  logic [LIMIT_W-1:0] reset_limit,
   output logic [BYTE_W-1:0]  rsp_data_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_last,
   output logic               rsp_more_pending,
   output logic [WIDTH_W-1:0] rsp_next_width,
   output logic               rsp_end_of_stream,
   output logic               rsp_valid,
   input  logic               rsp_ready
);

   localparam int LVL_W      = MAX_CODE_BITS + 1;
   localparam int CODE_LIMIT = 1 << MAX_CODE_BITS;
   localparam int CNT_W      = $clog2(BYTES_PER_ITEM + 1);

   // memories
   logic [CODE_W-1:0] prefix_mem [CODE_LIMIT];
   logic [BYTE_W-1:0] suffix_mem [CODE_LIMIT];
   logic [BYTE_W-1:0] stack_mem  [CODE_LIMIT];
   logic [CODE_W-1:0] prefix_q;
   logic [BYTE_W-1:0] suffix_q;
   logic [BYTE_W-1:0] stack_q;

   state_type state_ff, state_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [LVL_W-1:0]   next_code_ff, next_code_in;
   logic [LVL_W-1:0]   width_limit_ff, width_limit_in;
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [CODE_W-1:0]  prev_ff, prev_in;
   logic               expect_lit_ff, expect_lit_in;
   logic               finished_ff, finished_in;
   logic [CODE_W-1:0]  cur_ff, cur_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               unknown_ff, unknown_in;
   logic [BYTE_W-1:0]  first_ff, first_in;
   logic               pend_ff, pend_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [BYTE_W-1:0]  out_data_ff, out_data_in;
   logic               out_bv_ff, out_bv_in;
   logic               out_last_ff, out_last_in;
   logic               out_more_ff, out_more_in;
   logic [WIDTH_W-1:0] out_width_ff, out_width_in;
   logic               out_eos_ff, out_eos_in;
   logic               out_valid_ff, out_valid_in;

   logic                     dict_rd, dict_we;
   logic [MAX_CODE_BITS-1:0] dict_addr;
   logic                     stk_we, stk_rd;
   logic [MAX_CODE_BITS-1:0] stk_wa, stk_ra;
   logic [BYTE_W-1:0]        stk_wd;
   logic                     slot_free;
   logic [LVL_W-1:0]         next_inc;

   assign slot_free = !out_valid_ff || rsp_ready;

   // control sequencer
   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      next_code_in   = next_code_ff;
      width_limit_in = width_limit_ff;
      width_in       = width_ff;
      prev_in        = prev_ff;
      expect_lit_in  = expect_lit_ff;
      finished_in    = finished_ff;
      cur_in         = cur_ff;
      code_in        = code_ff;
      unknown_in     = unknown_ff;
      first_in       = first_ff;
      pend_in        = pend_ff;
      cnt_in         = cnt_ff;
      out_data_in    = out_data_ff;
      out_bv_in      = out_bv_ff;
      out_last_in    = out_last_ff;
      out_more_in    = out_more_ff;
      out_width_in   = out_width_ff;
      out_eos_in     = out_eos_ff;
      out_valid_in   = (out_valid_ff && !rsp_ready);
      item_ready     = 1'b0;
      dict_rd        = 1'b0;
      dict_we        = 1'b0;
      dict_addr      = MAX_CODE_BITS'(32'(cur_ff));
      stk_we         = 1'b0;
      stk_wa         = level_ff[MAX_CODE_BITS-1:0];
      stk_wd         = suffix_q;
      stk_rd         = 1'b0;
      stk_ra         = level_ff[MAX_CODE_BITS-1:0] - 1'b1;
      next_inc       = next_code_ff;

      unique case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               state_in = ST_DRAIN_START;
               if (item.op == OP_CODE && level_ff == '0 && !finished_ff) begin
                  if (expect_lit_ff) begin
                     stk_we        = 1'b1;
                     stk_wa        = '0;
                     stk_wd        = item.code[BYTE_W-1:0];
                     level_in      = LVL_W'(1);
                     prev_in       = {{(CODE_W-BYTE_W){1'b0}}, item.code[BYTE_W-1:0]};
                     expect_lit_in = 1'b0;
                  end else if (item.is_end) begin
                     finished_in = 1'b1;
                  end else begin
                     code_in    = item.code;
                     unknown_in = (32'(item.code) >= 32'(next_code_ff));
                     cur_in     = unknown_in ? prev_ff : item.code;
                     level_in   = unknown_in ? LVL_W'(1) : '0;
                     state_in   = ST_WALK_RD;
                  end
               end
            end
         end
         // one chain step: read entry, then push its suffix
         ST_WALK_RD: begin
            if (cur_ff > END_CODE && 32'(level_ff) < CODE_LIMIT - 1) begin
               dict_rd  = 1'b1;
               state_in = ST_WALK_USE;
            end else begin
               state_in = ST_FIRST;
            end
         end
         ST_WALK_USE: begin
            stk_we   = 1'b1;
            stk_wd   = suffix_q;
            level_in = level_ff + 1'b1;
            cur_in   = prefix_q;
            state_in = ST_WALK_RD;
         end
         ST_FIRST: begin
            first_in = cur_ff[BYTE_W-1:0];
            stk_we   = 1'b1;
            stk_wd   = cur_ff[BYTE_W-1:0];
            level_in = level_ff + 1'b1;
            state_in = ST_FIX;
         end
         // new entry, width growth, count update and dictionary reset at the limit
         ST_FIX: begin
            stk_we    = unknown_ff;
            stk_wa    = '0;
            stk_wd    = first_ff;
            dict_addr = next_code_ff[MAX_CODE_BITS-1:0];
            if (32'(next_code_ff) < CODE_LIMIT) begin
               dict_we  = 1'b1;
               next_inc = next_code_ff + 1'b1;
               if (32'(width_ff) < MAX_CODE_BITS &&
                   next_code_ff == width_limit_ff - 1'b1) begin
                  width_in       = width_ff + 1'b1;
                  width_limit_in = width_limit_ff << 1;
               end
            end
            prev_in      = code_ff;
            next_code_in = next_inc;
            if (32'(next_inc) == 32'(reset_limit)) begin
               next_code_in   = LVL_W'(FIRST_FREE);
               width_in       = START_WIDTH;
               width_limit_in = LVL_W'(START_WIDTH_LIMIT);
               expect_lit_in  = 1'b1;
            end
            state_in = ST_DRAIN_START;
         end
         ST_DRAIN_START: begin
            pend_in  = (32'(level_ff) > BYTES_PER_ITEM);
            cnt_in   = '0;
            state_in = (level_ff == '0) ? ST_EMPTY_OUT : ST_DRAIN_RD;
         end
         ST_DRAIN_RD: begin
            stk_rd   = 1'b1;
            level_in = level_ff - 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_data_in  = stack_q;
               out_bv_in    = 1'b1;
               out_last_in  = (32'(cnt_ff) == BYTES_PER_ITEM) || (level_ff == '0);
               out_more_in  = pend_ff;
               out_width_in = width_ff;
               out_eos_in   = finished_ff;
               state_in     = out_last_in ? ST_IDLE : ST_DRAIN_RD;
            end
         end
         ST_EMPTY_OUT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_data_in  = '0;
               out_bv_in    = 1'b0;
               out_last_in  = 1'b1;
               out_more_in  = 1'b0;
               out_width_in = width_ff;
               out_eos_in   = finished_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         level_ff       <= '0;
         next_code_ff   <= LVL_W'(FIRST_FREE);
         width_ff       <= START_WIDTH;
         width_limit_ff <= LVL_W'(START_WIDTH_LIMIT);
         prev_ff        <= '0;
         expect_lit_ff  <= 1'b1;
         finished_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         level_ff       <= level_in;
         next_code_ff   <= next_code_in;
         width_ff       <= width_in;
         width_limit_ff <= width_limit_in;
         prev_ff        <= prev_in;
         expect_lit_ff  <= expect_lit_in;
         finished_ff    <= finished_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      code_ff      <= code_in;
      unknown_ff   <= unknown_in;
      first_ff     <= first_in;
      pend_ff      <= pend_in;
      cnt_ff       <= cnt_in;
      out_data_ff  <= out_data_in;
      out_bv_ff    <= out_bv_in;
      out_last_ff  <= out_last_in;
      out_more_ff  <= out_more_in;
      out_width_ff <= out_width_in;
      out_eos_ff   <= out_eos_in;
   end

   // dictionary memories
   always_ff @(posedge clock) begin
      if (dict_we) begin
         prefix_mem[dict_addr] <= prev_ff;
         suffix_mem[dict_addr] <= first_ff;
      end
      if (dict_rd) begin
         prefix_q <= prefix_mem[dict_addr];
         suffix_q <= suffix_mem[dict_addr];
      end
   end

   // string stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      if (stk_rd) begin
         stack_q <= stack_mem[stk_ra];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_byte_valid    = out_bv_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_more_pending  = out_more_ff;
   assign rsp_next_width    = out_width_ff;
   assign rsp_end_of_stream = out_eos_ff;

endmodule

// ===== hdl/lzw_code_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lzw_code_decoder_unit
// LZW code decoder with 9 to MAX_CODE_BITS bit codes and string output.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req     | in        | op, code
//  rsp     | out       | data_byte, byte_valid, last, more_pending,
//          |           | next_width, end_of_stream
//  csr     | in        | data (reset_limit)
//
// A code walks its chain one link at a time through the one dictionary read
// port, then pops its bytes, at most BYTES_PER_ITEM per item, one at a time
// from the stack memory port.
// Reset is synchronous; memories are not cleared. A stalled rsp only holds
// the back end; the front queue still takes two items.
module lzw_code_decoder_unit
   import lzwcd_pkg::*;
#(
   parameter int BYTES_PER_ITEM = 64
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [CODE_W-1:0]  req_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_data_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_last,
   output logic               rsp_more_pending,
   output logic [WIDTH_W-1:0] rsp_next_width,
   output logic               rsp_end_of_stream,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   logic [LIMIT_W-1:0] reset_limit_ff;
   logic               item_valid, item_ready;
   item_type           item;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_limit_ff <= LIMIT_AT_RESET;
      end else if (csr_valid) begin
         reset_limit_ff <= csr_data;
      end
   end

   lzwcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_code   (req_code),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   lzwcd_back #(
      .BYTES_PER_ITEM (BYTES_PER_ITEM)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .item_ready        (item_ready),
      .reset_limit       (reset_limit_ff),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last          (rsp_last),
      .rsp_more_pending  (rsp_more_pending),
      .rsp_next_width    (rsp_next_width),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready)
   );

endmodule
